>>> rtl/framebuffer_alpha_blend_macros.svh
// Assertion helpers used by the framebuffer_alpha_blend top level.
// Each macro expects clk_i and rst_ni in scope.
`ifndef FRAMEBUFFER_ALPHA_BLEND_MACROS_SVH
`define FRAMEBUFFER_ALPHA_BLEND_MACROS_SVH

// The property must hold at every clock edge out of reset.
`define FAB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// The condition must never be true at a clock edge out of reset.
`define FAB_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

>>> rtl/fab_pkg.sv
package fab_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  // Holds frame dimensions up to 4096 and any non-negative coordinate.
  localparam int CMP_W = 13;

  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;
  localparam logic [CFG_W-1:0]     FRAME_DIM_RESET  = 9'd256;

  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_BLEND = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

  localparam logic [7:0] CH_MAX = 8'hFF;

  // Result queue between the pipeline and the output port.
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  typedef struct packed {
    logic              start;
    logic [CMP_W-1:0]  width;
    logic [CMP_W-1:0]  height;
    logic [31:0]       color;
  } clr_cmd_t;

  // Exact floor(v/255) for any v up to 255*255.
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] s;
    s = 17'(v) + 17'd1 + 17'(v >> 8);
    return s[15:8];
  endfunction

endpackage

>>> rtl/fab_ram.sv
module fab_ram #(
  parameter int Width = 32,
  parameter int Depth = 65536,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // A read at the address being written returns the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/fab_blend.sv
module fab_blend import fab_pkg::*; (
  input  logic [31:0] dst_i,
  input  logic [31:0] src_i,
  input  logic [7:0]  a2_i,
  output logic [31:0] pixel_o
);

  logic [7:0]  inv_a;
  logic [15:0] mix [3];
  logic [7:0]  chan [3];
  logic [7:0]  dst_a;

  assign inv_a = CH_MAX - a2_i;
  assign dst_a = dst_i[7:0];

  // Red, green and blue sit at bytes 3, 2 and 1; the sum never exceeds 255*255.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mix[c]  = 16'(dst_i[8*(3-c) +: 8]) * 16'(inv_a)
              + 16'(src_i[8*(3-c) +: 8]) * 16'(a2_i);
      chan[c] = div255(mix[c]);
    end
  end

  assign pixel_o = {chan[0], chan[1], chan[2], (dst_a > a2_i) ? dst_a : a2_i};

endmodule

>>> rtl/fab_clear.sv
module fab_clear import fab_pkg::*; #(
  parameter int MaxWidth  = MAX_WIDTH_DEF,
  parameter int MaxHeight = MAX_HEIGHT_DEF,
  localparam int Depth = MaxWidth * MaxHeight,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  clr_cmd_t         cmd_i,
  output logic             busy_o,
  output logic             we_o,
  output logic [AddrW-1:0] waddr_o,
  output logic [31:0]      wdata_o
);

  logic             busy_q, busy_d;
  logic [CMP_W-1:0] col_q, col_d, row_q, row_d;
  logic [CMP_W-1:0] w_q, w_d, h_q, h_d;
  logic [AddrW-1:0] base_q, base_d;
  logic [31:0]      color_q, color_d;

  always_comb begin
    busy_d  = busy_q;
    col_d   = col_q;
    row_d   = row_q;
    w_d     = w_q;
    h_d     = h_q;
    base_d  = base_q;
    color_d = color_q;
    if (busy_q) begin
      if (col_q == w_q - 1'b1) begin
        col_d = '0;
        if (row_q == h_q - 1'b1) begin
          busy_d = 1'b0;
        end else begin
          row_d  = row_q + 1'b1;
          base_d = base_q + AddrW'(MaxWidth);
        end
      end else begin
        col_d = col_q + 1'b1;
      end
    end else if (cmd_i.start) begin
      // An empty frame has nothing to fill.
      busy_d  = (cmd_i.width != '0) && (cmd_i.height != '0);
      col_d   = '0;
      row_d   = '0;
      base_d  = '0;
      w_d     = cmd_i.width;
      h_d     = cmd_i.height;
      color_d = cmd_i.color;
    end
  end

  // Reset starts a pass over the whole store that writes zero words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b1;
      col_q   <= '0;
      row_q   <= '0;
      base_q  <= '0;
      w_q     <= CMP_W'(MaxWidth);
      h_q     <= CMP_W'(MaxHeight);
      color_q <= '0;
    end else begin
      busy_q  <= busy_d;
      col_q   <= col_d;
      row_q   <= row_d;
      base_q  <= base_d;
      w_q     <= w_d;
      h_q     <= h_d;
      color_q <= color_d;
    end
  end

  assign busy_o  = busy_q;
  assign we_o    = busy_q;
  assign waddr_o = base_q + AddrW'(col_q);
  assign wdata_o = color_q;

endmodule

>>> rtl/framebuffer_alpha_blend.sv
// RGBA frame store with write, read, blend and clear operations.
// Input words arrive on s_axis: tuser carries the operation, tdata the
// coordinates, colour and opacity. Each accepted word yields exactly one
// result word on m_axis: the read pixel in tdata and the bounds flag in tuser.
// The user writes frame_width and frame_height through cfg_we_i, cfg_index_i
// and cfg_wdata_i only while the block is idle; the block does not enforce it.
// Pixel operations take one word per cycle while tready is high; a result
// word passes stages A and B and the result queue before it is presented.
// The store is one memory with one read and one
// write port: the read is issued one stage before the write-back, and a
// blend or read that follows a write to the same pixel takes the new word
// from a forwarding register.
// A clear fills the configured frame one pixel per cycle and occupies the
// write port until the fill is done; no word is accepted during the fill.
// After reset the store is zeroed the same way, over all MaxWidth*MaxHeight
// pixels (65536 with the default sizes).
// Results wait in a four-entry queue; when the receiver stalls, input words
// are taken until the queue and pipeline hold four words, then tready drops.
`include "framebuffer_alpha_blend_macros.svh"

module framebuffer_alpha_blend import fab_pkg::*; #(
  parameter int MaxWidth  = MAX_WIDTH_DEF,
  parameter int MaxHeight = MAX_HEIGHT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // x [11:0], y [23:12], pixel_color [55:24], opacity [63:56]
  input  logic [63:0]          s_axis_tdata,
  // operation [1:0]
  input  logic [OP_W-1:0]      s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // read_color [31:0]
  output logic [31:0]          m_axis_tdata,
  // in_bounds [0]
  output logic                 m_axis_tuser,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam int Depth = MaxWidth * MaxHeight;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  // Configuration.
  logic [CFG_W-1:0] frame_width_q, frame_height_q;
  logic [CMP_W-1:0] fw_ext, fh_ext, w_eff, h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_DIM_RESET;
      frame_height_q <= FRAME_DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign fw_ext = CMP_W'(frame_width_q);
  assign fh_ext = CMP_W'(frame_height_q);
  assign w_eff  = (fw_ext > CMP_W'(MaxWidth))  ? CMP_W'(MaxWidth)  : fw_ext;
  assign h_eff  = (fh_ext > CMP_W'(MaxHeight)) ? CMP_W'(MaxHeight) : fh_ext;

  // Input decode.
  logic                 s_accept;
  logic signed [11:0]   in_x, in_y;
  logic [31:0]          in_color;
  logic [7:0]           in_opacity;
  logic                 in_inb;
  logic [2*CMP_W-1:0]   lin_addr;

  assign s_accept   = s_axis_tvalid && s_axis_tready;
  assign in_x       = s_axis_tdata[11:0];
  assign in_y       = s_axis_tdata[23:12];
  assign in_color   = s_axis_tdata[55:24];
  assign in_opacity = s_axis_tdata[63:56];

  assign in_inb = !in_x[11] && !in_y[11]
               && (CMP_W'(in_x[10:0]) < w_eff) && (CMP_W'(in_y[10:0]) < h_eff);
  assign lin_addr = (2*CMP_W)'(in_y[10:0]) * (2*CMP_W)'(MaxWidth)
                  + (2*CMP_W)'(in_x[10:0]);

  // Stage A: the memory read is issued from these registers.
  logic             a_valid_q;
  logic [OP_W-1:0]  a_op_q;
  logic             a_inb_q;
  logic [AddrW-1:0] a_addr_q;
  logic [31:0]      a_color_q;
  logic [15:0]      a_prod_q;

  // Stage B: read data arrives, the new word is written back.
  logic             b_valid_q;
  logic [OP_W-1:0]  b_op_q;
  logic             b_inb_q;
  logic [AddrW-1:0] b_addr_q;
  logic [31:0]      b_color_q;
  logic [7:0]       b_a2_q;
  logic             fwd_q;
  logic [31:0]      fwd_data_q;

  logic [31:0] ram_rdata, b_dst, b_blend, b_wdata;
  logic        b_wr, fwd_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      a_valid_q <= s_accept;
      b_valid_q <= a_valid_q;
      fwd_q     <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_op_q     <= s_axis_tuser;
    a_inb_q    <= in_inb;
    a_addr_q   <= lin_addr[AddrW-1:0];
    a_color_q  <= in_color;
    a_prod_q   <= 16'(in_color[7:0]) * 16'(in_opacity);
    b_op_q     <= a_op_q;
    b_inb_q    <= a_inb_q;
    b_addr_q   <= a_addr_q;
    b_color_q  <= a_color_q;
    b_a2_q     <= div255(a_prod_q);
    fwd_data_q <= b_wdata;
  end

  // A read issued while the older word writes the same pixel sees stale data.
  assign fwd_d = b_wr && a_valid_q && (a_addr_q == b_addr_q);
  assign b_dst = fwd_q ? fwd_data_q : ram_rdata;

  fab_blend u_blend (
    .dst_i   (b_dst),
    .src_i   (b_color_q),
    .a2_i    (b_a2_q),
    .pixel_o (b_blend)
  );

  assign b_wr    = b_valid_q && b_inb_q && ((b_op_q == OP_WRITE) || (b_op_q == OP_BLEND));
  assign b_wdata = (b_op_q == OP_WRITE) ? b_color_q : b_blend;

  // Clear sequencer and memory.
  clr_cmd_t         clr_cmd;
  logic             clr_busy, clr_we;
  logic [AddrW-1:0] clr_waddr;
  logic [31:0]      clr_wdata;

  assign clr_cmd.start  = b_valid_q && (b_op_q == OP_CLEAR);
  assign clr_cmd.width  = w_eff;
  assign clr_cmd.height = h_eff;
  assign clr_cmd.color  = b_color_q;

  fab_clear #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_clear (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (clr_cmd),
    .busy_o  (clr_busy),
    .we_o    (clr_we),
    .waddr_o (clr_waddr),
    .wdata_o (clr_wdata)
  );

  fab_ram #(
    .Width (32),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (clr_we || b_wr),
    .waddr_i (clr_we ? clr_waddr : b_addr_q),
    .wdata_i (clr_we ? clr_wdata : b_wdata),
    .raddr_i (a_addr_q),
    .rdata_o (ram_rdata)
  );

  // Result queue.
  logic [31:0]          q_color_q [OUT_DEPTH];
  logic                 q_inb_q   [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] q_wptr_q, q_rptr_q;
  logic [OUT_CNT_W-1:0] q_cnt_q, in_flight;
  logic                 q_push, q_pop;
  logic [31:0]          res_color;
  logic                 res_inb;

  assign res_color = (b_op_q == OP_READ && b_inb_q) ? b_dst : 32'd0;
  assign res_inb   = b_inb_q && (b_op_q != OP_CLEAR);
  assign q_push    = b_valid_q;
  assign q_pop     = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (q_push) begin
      q_color_q[q_wptr_q] <= res_color;
      q_inb_q[q_wptr_q]   <= res_inb;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wptr_q <= '0;
      q_rptr_q <= '0;
      q_cnt_q  <= '0;
    end else begin
      if (q_push) begin
        q_wptr_q <= q_wptr_q + 1'b1;
      end
      if (q_pop) begin
        q_rptr_q <= q_rptr_q + 1'b1;
      end
      q_cnt_q <= q_cnt_q + OUT_CNT_W'(q_push) - OUT_CNT_W'(q_pop);
    end
  end

  assign m_axis_tvalid = (q_cnt_q != '0);
  assign m_axis_tdata  = q_color_q[q_rptr_q];
  assign m_axis_tuser  = q_inb_q[q_rptr_q];

  // Every word in the pipeline has a queue slot reserved, and nothing enters
  // behind a clear until the fill is done.
  logic clr_pending;

  assign in_flight   = q_cnt_q + OUT_CNT_W'(a_valid_q) + OUT_CNT_W'(b_valid_q);
  assign clr_pending = (a_valid_q && a_op_q == OP_CLEAR) || (b_valid_q && b_op_q == OP_CLEAR);
  assign s_axis_tready = !clr_busy && !clr_pending && (in_flight < OUT_CNT_W'(OUT_DEPTH));

  `FAB_ASSERT_NEVER(a_single_writer, clr_we && b_wr, "fill and write-back collide")
  `FAB_ASSERT(a_no_accept_in_fill, clr_busy |-> !s_axis_tready, "word accepted during fill")
  `FAB_ASSERT(a_queue_bound, in_flight <= OUT_CNT_W'(OUT_DEPTH), "result queue overrun")
  `FAB_ASSERT(a_fwd_has_word, fwd_q |-> b_valid_q, "forwarding without a word in stage B")

endmodule
